// ===== hw/rtl/wt_pkg.sv =====
// Shared types, constants and character classes for the word tokenizer.
// Used by the channel interfaces, the controller, the datapath and the top level.
package wt_pkg;

	localparam int DEF_MAX_WORD_CHARS = 10;
	localparam int CNT_W              = 4;
	localparam int LEN_W              = 4;
	localparam int MIN_W              = 4;
	localparam int BYTE_W             = 8;
	localparam int CODE_W             = 5;
	localparam int LETTER_SLOTS       = 10;
	localparam int LETTERS_W          = LETTER_SLOTS * CODE_W;

	localparam logic [MIN_W-1:0]  MIN_LEN_RESET = 4'd3;

	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_RPAR  = 8'h29;
	localparam logic [BYTE_W-1:0] CH_APOS  = 8'h27;
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
	localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3F;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_UC_A  = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UC_Z  = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_LC_A  = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LC_Z  = 8'h7A;
	localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

	typedef enum logic {
		ST_COLLECT,
		ST_SKIP
	} wt_state_t;

	typedef struct packed {
		logic push;
		logic clear;
		logic load;
		logic cfg_wr;
	} wt_cmd_t;

	typedef struct packed {
		logic full;
		logic is_sep;
		logic word_ok;
	} wt_sts_t;

	function automatic logic is_sep(input logic [BYTE_W-1:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
			c == CH_SLASH || c == CH_DASH;
	endfunction

	function automatic logic is_mark(input logic [BYTE_W-1:0] c);
		return c == CH_DOT || c == CH_COLON || c == CH_SEMI || c == CH_RPAR ||
			c == CH_APOS || c == CH_QUOTE || c == CH_BANG || c == CH_QMARK ||
			c == CH_COMMA || c == CH_SLASH;
	endfunction

	function automatic logic is_letter(input logic [BYTE_W-1:0] c);
		return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
	endfunction

	function automatic logic [CODE_W-1:0] letter_code(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] diff;
		diff = (c | CASE_BIT) - CH_LC_A;
		return diff[CODE_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/wt_byte_if.sv =====
// Input byte channel: valid/ready handshake with one text byte per beat.
// Depends on wt_pkg.
interface wt_byte_if;
	import wt_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

// ===== hw/rtl/wt_word_if.sv =====
// Output word channel: valid/ready handshake with packed letter codes and length.
// Depends on wt_pkg.
interface wt_word_if;
	import wt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [LETTERS_W-1:0] word_letters;
	logic [LEN_W-1:0]     word_length;

	modport source (output valid, output word_letters, output word_length, input ready);
	modport sink (input valid, input word_letters, input word_length, output ready);
endinterface

// ===== hw/rtl/wt_cfg_if.sv =====
// Configuration write channel carrying the minimum word length.
// Depends on wt_pkg.
interface wt_cfg_if;
	import wt_pkg::*;

	logic             valid;
	logic             ready;
	logic [MIN_W-1:0] min_word_length;

	modport source (output valid, output min_word_length, input ready);
	modport sink (input valid, input min_word_length, output ready);
endinterface

// ===== hw/rtl/word_tokenizer_unit.sv =====
// Top level of the word tokenizer: joins the channels to wt_ctrl and wt_datapath.
// A word that passes the word check is presented in the cycle after its separator beat is accepted.
// Throughput: one text byte per cycle; input stalls while a finished word waits on
// a low word_out.ready. Reset clears the count, the skip state, the result valid and
// sets the minimum length to 3; buffered characters are not cleared.
module word_tokenizer_unit #(
	parameter int MAX_WORD_CHARS = wt_pkg::DEF_MAX_WORD_CHARS
) (
	input logic       clk,
	input logic       arst_n,
	wt_byte_if.sink   byte_in,
	wt_word_if.source word_out,
	wt_cfg_if.sink    cfg
);
	import wt_pkg::*;

	wt_cmd_t cmd;
	wt_sts_t sts;

	wt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (byte_in.valid),
		.in_ready  (byte_in.ready),
		.out_valid (word_out.valid),
		.out_ready (word_out.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wt_datapath #(
		.MAX_WORD_CHARS (MAX_WORD_CHARS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_byte    (byte_in.text_byte),
		.cfg_min      (cfg.min_word_length),
		.cmd          (cmd),
		.sts          (sts),
		.word_letters (word_out.word_letters),
		.word_length  (word_out.word_length)
	);

endmodule

// ===== hw/rtl/wt_datapath.sv =====
// Datapath: character flag buffer, count, length register, word check and result register.
// Driven by wt_ctrl commands; depends on wt_pkg.
module wt_datapath #(
	parameter int MAX_WORD_CHARS = wt_pkg::DEF_MAX_WORD_CHARS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [wt_pkg::BYTE_W-1:0]    text_byte,
	input  logic [wt_pkg::MIN_W-1:0]     cfg_min,
	input  wt_pkg::wt_cmd_t              cmd,
	output wt_pkg::wt_sts_t              sts,
	output logic [wt_pkg::LETTERS_W-1:0] word_letters,
	output logic [wt_pkg::LEN_W-1:0]     word_length
);
	import wt_pkg::*;

	localparam int IDX_W  = $clog2(MAX_WORD_CHARS);
	localparam int NSLOTS = (MAX_WORD_CHARS < LETTER_SLOTS) ? MAX_WORD_CHARS : LETTER_SLOTS;

	logic [CNT_W-1:0]          count_q;
	logic [MIN_W-1:0]          min_q;
	logic [MAX_WORD_CHARS-1:0] letter_q;
	logic [MAX_WORD_CHARS-1:0] mark_q;
	logic [MAX_WORD_CHARS-1:0] apos_q;
	logic [CODE_W-1:0]         code_q [MAX_WORD_CHARS];
	logic [LETTERS_W-1:0]      letters_q;
	logic [LEN_W-1:0]          length_q;

	logic [IDX_W-1:0]     wr_idx;
	logic [CNT_W-1:0]     len_strip;
	logic [CNT_W-1:0]     len_word;
	logic [CNT_W-1:0]     need;
	logic                 cut;
	logic                 all_letters;
	logic [LETTERS_W-1:0] letters;

	assign wr_idx = count_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= MIN_LEN_RESET;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.push) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.cfg_wr) begin
				min_q <= cfg_min;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			letter_q[wr_idx] <= is_letter(text_byte);
			mark_q[wr_idx]   <= is_mark(text_byte);
			apos_q[wr_idx]   <= (text_byte == CH_APOS);
			code_q[wr_idx]   <= letter_code(text_byte);
		end
		if (cmd.load) begin
			letters_q <= letters;
			length_q  <= LEN_W'(len_word);
		end
	end

	always_comb begin
		len_strip = '0;
		for (int i = 0; i < MAX_WORD_CHARS; i++) begin
			if (CNT_W'(i) < count_q && !mark_q[i]) begin
				len_strip = CNT_W'(i + 1);
			end
		end
		cut = 1'b0;
		for (int i = 0; i < MAX_WORD_CHARS; i++) begin
			if (CNT_W'(i + 2) == len_strip && apos_q[i]) begin
				cut = 1'b1;
			end
		end
		len_word = cut ? len_strip - CNT_W'(2) : len_strip;
		need = (min_q == '0) ? CNT_W'(1) : CNT_W'(min_q);
		all_letters = 1'b1;
		for (int i = 0; i < MAX_WORD_CHARS; i++) begin
			if (CNT_W'(i) < len_word && !letter_q[i]) begin
				all_letters = 1'b0;
			end
		end
		letters = '0;
		for (int i = 0; i < NSLOTS; i++) begin
			if (CNT_W'(i) < len_word) begin
				letters[CODE_W*i +: CODE_W] = code_q[i];
			end
		end
	end

	assign sts.full    = (count_q == CNT_W'(MAX_WORD_CHARS));
	assign sts.is_sep  = is_sep(text_byte);
	assign sts.word_ok = (len_word >= need) && all_letters;

	assign word_letters = letters_q;
	assign word_length  = length_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_WORD_CHARS))
		else $error("buffer count beyond capacity");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !sts.full)
		else $error("push into a full buffer");

	a_load_length: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (word_length != '0) && (CNT_W'(word_length) <= CNT_W'(MAX_WORD_CHARS)))
		else $error("loaded word length out of range");

endmodule

// ===== hw/rtl/wt_ctrl.sv =====
// Controller: collect/skip state machine, handshakes and result-valid register.
// Commands wt_datapath; depends on wt_pkg.
module wt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  wt_pkg::wt_sts_t sts,
	output wt_pkg::wt_cmd_t cmd
);
	import wt_pkg::*;

	wt_state_t state_q;
	wt_state_t state_d;
	logic      out_valid_q;
	logic      accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_COLLECT: begin
				if (accept && !sts.is_sep && sts.full) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (accept && sts.is_sep) begin
					state_d = ST_COLLECT;
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.cfg_wr = cfg_valid;
		case (state_q)
			ST_COLLECT: begin
				cmd.push  = accept && !sts.is_sep && !sts.full;
				cmd.clear = accept && (sts.is_sep || sts.full);
				cmd.load  = accept && sts.is_sep && sts.word_ok;
			end
			ST_SKIP: begin
				cmd.push  = 1'b0;
			end
			default: begin
				cmd.clear = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_skip_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SKIP |-> !cmd.push && !cmd.load)
		else $error("buffer activity while skipping");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(accept && sts.is_sep && state_q == ST_COLLECT))
		else $error("result without an accepted separator");

	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !out_valid_q || out_ready)
		else $error("result register overwritten");

endmodule
